// ===== src/ictl_pkg.sv =====
// Shared types and constants for the instruction cache tag directory.
// Used by ictl_victim and icache_tag_lookup_lru. No dependencies.
package ictl_pkg;

	localparam int WAYS        = 2;
	localparam int SET_BITS    = 10;
	localparam int OFFSET_BITS = 6;
	localparam int ADDR_BITS   = 32;

	localparam int FETCH_BITS = 32;
	localparam int EXT_BITS   = (ADDR_BITS > FETCH_BITS) ? ADDR_BITS : FETCH_BITS;
	localparam int TAG_BITS   = ADDR_BITS - SET_BITS - OFFSET_BITS;
	localparam int WAY_BITS   = $clog2(WAYS);
	localparam int NUM_SETS   = 1 << SET_BITS;
	localparam int LINE_BITS  = SET_BITS + WAY_BITS;
	localparam int NUM_LINES  = 1 << LINE_BITS;
	localparam int OUT_WAY_BITS = 3;
	localparam int OUT_DATA_BITS = 8;

	// per-set directory state: valid bits and LRU ranks (0 = most recent)
	typedef struct packed {
		logic [WAYS-1:0]               valid;
		logic [WAYS-1:0][WAY_BITS-1:0] rank;
	} meta_t;

	function automatic meta_t meta_reset_row();
		meta_t m;
		m.valid = '0;
		for (int w = 0; w < WAYS; w++) begin
			m.rank[w] = WAY_BITS'(w);
		end
		return m;
	endfunction

endpackage

// ===== src/ictl_victim.sv =====
// Way selection and LRU promotion for one set of the tag directory.
// Depends on ictl_pkg.
module ictl_victim (
	input  ictl_pkg::meta_t                  meta,
	input  logic                             hit,
	input  logic [ictl_pkg::WAY_BITS-1:0]    hit_way,
	output logic [ictl_pkg::WAY_BITS-1:0]    chosen,
	output ictl_pkg::meta_t                  meta_nxt
);
	import ictl_pkg::*;

	logic [WAY_BITS-1:0] inv_way;
	logic                inv_found;
	logic [WAY_BITS-1:0] lru_way;
	logic [WAY_BITS-1:0] old_rank;

	// lowest invalid way, else the least recently used one
	always_comb begin
		inv_way   = '0;
		inv_found = 1'b0;
		lru_way   = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (!meta.valid[w]) begin
				inv_way   = WAY_BITS'(w);
				inv_found = 1'b1;
			end
			if (meta.rank[w] == WAY_BITS'(WAYS - 1)) begin
				lru_way = WAY_BITS'(w);
			end
		end
	end

	always_comb begin
		if (hit) begin
			chosen = hit_way;
		end else if (inv_found) begin
			chosen = inv_way;
		end else begin
			chosen = lru_way;
		end
	end

	assign old_rank = meta.rank[chosen];

	always_comb begin
		meta_nxt = meta;
		meta_nxt.valid[chosen] = 1'b1;
		for (int w = 0; w < WAYS; w++) begin
			if (meta.rank[w] < old_rank) begin
				meta_nxt.rank[w] = meta.rank[w] + 1'b1;
			end
		end
		meta_nxt.rank[chosen] = '0;
	end

endmodule

// ===== src/icache_tag_lookup_lru.sv =====
// Instruction cache tag directory with true-LRU replacement.
// Depends on ictl_pkg and ictl_victim.
//
// Usage:
//   Slave stream (s_*) takes one fetch address per request; master stream
//   (m_*) returns one result per request: hit flag and way (hit or filled).
//   The set's valid/rank row and the tags are held in synchronous memories.
//   One tag comparator is reused across the ways: after acceptance the block
//   reads and compares one way per cycle, stopping at the first hit, then
//   writes back the LRU row (and the tag on a miss) in the update state.
//   A request occupies the block from acceptance through scan and write-back;
//   the next request is taken only once the block is idle again.
//   s_tready is high only while idle.
//   After reset a clearing pass writes every set row (NUM_SETS rows,
//   1024 at the default size); no request is taken during it.
//   The result sits in an output register; if the receiver stalls, the
//   block finishes the next request up to write-back and waits there until
//   the register frees.
module icache_tag_lookup_lru (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] fetch_address
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] hit, [3:1] way, [7:4] zero
);
	import ictl_pkg::*;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	logic [1:0]          state_q;
	logic [SET_BITS-1:0] clr_q;
	logic [WAY_BITS-1:0] way_q;
	logic                hit_q;
	logic [WAY_BITS-1:0] hit_way_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [SET_BITS-1:0] set_q;
	logic                m_tvalid_q;
	logic                res_hit_q;
	logic [WAY_BITS-1:0] res_way_q;

	meta_t               meta_mem [NUM_SETS];
	logic [TAG_BITS-1:0] tag_mem  [NUM_LINES];
	meta_t               meta_rd_q;
	logic [TAG_BITS-1:0] tag_rd_q;

	logic [EXT_BITS-1:0] addr_ext;
	logic [TAG_BITS-1:0] tag_in;
	logic [SET_BITS-1:0] set_in;
	logic                accept;
	logic                match;
	logic                last_way;
	logic                upd_go;
	logic                tag_rd_en;
	logic [LINE_BITS-1:0] tag_rd_addr;
	logic [WAY_BITS-1:0] chosen;
	meta_t               meta_nxt;

	assign addr_ext = EXT_BITS'(s_tdata);
	assign tag_in   = addr_ext[ADDR_BITS-1 -: TAG_BITS];
	assign set_in   = addr_ext[OFFSET_BITS +: SET_BITS];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// the shared comparator: one way per cycle
	assign match    = meta_rd_q.valid[way_q] && (tag_rd_q == tag_q);
	assign last_way = (way_q == WAY_BITS'(WAYS - 1));
	assign upd_go   = (state_q == ST_UPDATE) && (!m_tvalid_q || m_tready);

	assign tag_rd_en   = accept || ((state_q == ST_SCAN) && !match && !last_way);
	assign tag_rd_addr = accept ? {set_in, {WAY_BITS{1'b0}}} : {set_q, way_q + 1'b1};

	ictl_victim u_victim (
		.meta     (meta_rd_q),
		.hit      (hit_q),
		.hit_way  (hit_way_q),
		.chosen   (chosen),
		.meta_nxt (meta_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			way_q      <= '0;
			hit_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (upd_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						way_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= ST_UPDATE;
					end else if (last_way) begin
						hit_q   <= 1'b0;
						state_q <= ST_UPDATE;
					end else begin
						way_q <= way_q + 1'b1;
					end
				end
				ST_UPDATE: begin
					if (upd_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// request payload and result
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_q <= tag_in;
			set_q <= set_in;
		end
		if ((state_q == ST_SCAN) && match) begin
			hit_way_q <= way_q;
		end
		if (upd_go) begin
			res_hit_q <= hit_q;
			res_way_q <= chosen;
		end
	end

	// set row memory
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			meta_mem[clr_q] <= meta_reset_row();
		end else if (upd_go) begin
			meta_mem[set_q] <= meta_nxt;
		end
		if (accept) begin
			meta_rd_q <= meta_mem[set_in];
		end
	end

	// tag memory, addressed by {set, way}
	always_ff @(posedge clk) begin
		if (upd_go && !hit_q) begin
			tag_mem[{set_q, chosen}] <= tag_q;
		end
		if (tag_rd_en) begin
			tag_rd_q <= tag_mem[tag_rd_addr];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_BITS - OUT_WAY_BITS - 1){1'b0}},
		OUT_WAY_BITS'(res_way_q), res_hit_q};

	a_rise_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_UPDATE)
		else $error("result raised without a write-back cycle");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("request taken during clearing pass");

	a_chosen_promoted: assert property (@(posedge clk) disable iff (!arst_n)
		upd_go |-> (meta_nxt.valid[chosen] && (meta_nxt.rank[chosen] == '0)))
		else $error("chosen way not valid and most recent after update");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (way_q <= WAY_BITS'(WAYS - 1)))
		else $error("way scan beyond last way");

	a_hit_way_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && hit_q) |-> meta_rd_q.valid[hit_way_q])
		else $error("hit reported on an invalid way");

endmodule
